// ----- hw/rtl/ihpt_pkg.sv -----
// Shared constants, step codes and control structs for the hashed inverted page table.
// No dependencies; every other file but ihpt_ram uses it through scoped names.
package ihpt_pkg;

  localparam int FRAMES    = 256;
  localparam int FRAME_W   = 8;
  localparam int PTR_W     = 9;
  localparam int PID_W     = 4;
  localparam int VA_W      = 32;
  localparam int PAGE_BITS = 12;
  localparam int VPN_W     = VA_W - PAGE_BITS;
  localparam int INFO_W    = PID_W + VPN_W;
  localparam int CNT_W     = 9;
  localparam int PA_W      = FRAME_W + PAGE_BITS;

  // End-of-chain marker: one past the last frame.
  localparam logic [PTR_W-1:0] NIL = PTR_W'(FRAMES);

  // Datapath step codes.
  localparam logic [4:0] OP_NONE    = 5'd0;
  localparam logic [4:0] OP_CLEAR   = 5'd1;
  localparam logic [4:0] OP_ACCEPT  = 5'd2;
  localparam logic [4:0] OP_HEAD    = 5'd3;
  localparam logic [4:0] OP_CMP     = 5'd4;
  localparam logic [4:0] OP_HREAD   = 5'd5;
  localparam logic [4:0] OP_HLINK   = 5'd6;
  localparam logic [4:0] OP_HBEF    = 5'd7;
  localparam logic [4:0] OP_HPLACE1 = 5'd8;
  localparam logic [4:0] OP_HPLACE2 = 5'd9;
  localparam logic [4:0] OP_HOLD_RD = 5'd10;
  localparam logic [4:0] OP_HOLD_AD = 5'd11;
  localparam logic [4:0] OP_MISS    = 5'd12;
  localparam logic [4:0] OP_EINFO   = 5'd13;
  localparam logic [4:0] OP_EHEAD   = 5'd14;
  localparam logic [4:0] OP_ELINK   = 5'd15;
  localparam logic [4:0] OP_INS_RD  = 5'd16;
  localparam logic [4:0] OP_INS_WR  = 5'd17;
  localparam logic [4:0] OP_OUT     = 5'd18;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic head_nil;
    logic link_nil;
    logic match;
    logic cur_is_oldest;
    logic cur_is_frame;
    logic full;
    logic cmp_last;
    logic steps_last;
    logic clr_last;
  } sts_t;

endpackage

// ----- hw/rtl/ihpt_if.sv -----
// Valid/ready channel interfaces for the access words and the result words.
// Depends on ihpt_pkg for field widths.
interface ihpt_in_if;
  logic                          valid;
  logic                          ready;
  logic [ihpt_pkg::PID_W-1:0]    process_id;
  logic [ihpt_pkg::VA_W-1:0]     virtual_address;
  modport source (output valid, process_id, virtual_address, input ready);
  modport sink   (input valid, process_id, virtual_address, output ready);
endinterface

interface ihpt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          page_hit;
  logic [ihpt_pkg::FRAME_W-1:0]  frame_number;
  logic [ihpt_pkg::PA_W-1:0]     physical_address;
  logic                          bucket_was_empty;
  logic [ihpt_pkg::CNT_W-1:0]    chain_compares;
  logic                          frame_evicted;
  modport source (output valid, page_hit, frame_number, physical_address,
                  bucket_was_empty, chain_compares, frame_evicted, input ready);
  modport sink   (input valid, page_hit, frame_number, physical_address,
                  bucket_was_empty, chain_compares, frame_evicted, output ready);
endinterface

// ----- hw/rtl/inverted_hash_page_table_lru.sv -----
// Hashed inverted page table with LRU replacement; depends on ihpt_pkg, ihpt_if, ihpt_ram,
// ihpt_ctrl and ihpt_dp. Each access walks its bucket chain. A hit moves its frame to the newest
// ring place, or, for the oldest frame, just advances the oldest pointer. A miss takes the oldest
// frame, first unlinked from its victim chain when the table is full. A new word is taken only
// after the last result is loaded, and that load waits until the old result is taken.
// Synchronous active-low reset, then a clearing pass over all 256 frames with no input taken.
module inverted_hash_page_table_lru (
  input  logic  clk,
  input  logic  rst_n,
  ihpt_in_if.sink    in_ch,
  ihpt_out_if.source out_ch
);

  ihpt_pkg::cmd_t cmd;
  ihpt_pkg::sts_t sts;

  ihpt_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts,
    .cmd
  );

  ihpt_dp u_dp (
    .clk,
    .rst_n,
    .cmd,
    .sts,
    .in_pid    (in_ch.process_id),
    .in_va     (in_ch.virtual_address),
    .res_hit   (out_ch.page_hit),
    .res_frame (out_ch.frame_number),
    .res_pa    (out_ch.physical_address),
    .res_empty (out_ch.bucket_was_empty),
    .res_cmp   (out_ch.chain_compares),
    .res_evict (out_ch.frame_evicted)
  );

endmodule

// ----- hw/rtl/ihpt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ihpt_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ihpt_ctrl.sv -----
// Controller state machine: sequences lookup, ring update, eviction and insert.
// Depends on ihpt_pkg for step codes and the command and status structs.
module ihpt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ihpt_pkg::sts_t   sts,
  output ihpt_pkg::cmd_t   cmd
);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_HEAD    = 5'd2;
  localparam logic [4:0] S_CMP     = 5'd3;
  localparam logic [4:0] S_HREAD   = 5'd4;
  localparam logic [4:0] S_HLINK   = 5'd5;
  localparam logic [4:0] S_HBEF    = 5'd6;
  localparam logic [4:0] S_HPLACE1 = 5'd7;
  localparam logic [4:0] S_HPLACE2 = 5'd8;
  localparam logic [4:0] S_HOLD_RD = 5'd9;
  localparam logic [4:0] S_HOLD_AD = 5'd10;
  localparam logic [4:0] S_MISS    = 5'd11;
  localparam logic [4:0] S_EINFO   = 5'd12;
  localparam logic [4:0] S_EHEAD   = 5'd13;
  localparam logic [4:0] S_ELINK   = 5'd14;
  localparam logic [4:0] S_INS_RD  = 5'd15;
  localparam logic [4:0] S_INS_WR  = 5'd16;
  localparam logic [4:0] S_OUT     = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_out;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Next state and the step issued to the datapath.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = ihpt_pkg::OP_NONE;
    unique case (state_r)
      S_CLR: begin
        cmd.op = ihpt_pkg::OP_CLEAR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ihpt_pkg::OP_ACCEPT;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.op    = ihpt_pkg::OP_HEAD;
        state_nxt = sts.head_nil ? S_MISS : S_CMP;
      end
      S_CMP: begin
        cmd.op = ihpt_pkg::OP_CMP;
        if (sts.match) begin
          state_nxt = sts.cur_is_oldest ? S_HOLD_RD : S_HREAD;
        end else if (sts.link_nil || sts.cmp_last) begin
          state_nxt = S_MISS;
        end
      end
      S_HREAD: begin
        cmd.op    = ihpt_pkg::OP_HREAD;
        state_nxt = S_HLINK;
      end
      S_HLINK: begin
        cmd.op    = ihpt_pkg::OP_HLINK;
        state_nxt = S_HBEF;
      end
      S_HBEF: begin
        cmd.op    = ihpt_pkg::OP_HBEF;
        state_nxt = S_HPLACE1;
      end
      S_HPLACE1: begin
        cmd.op    = ihpt_pkg::OP_HPLACE1;
        state_nxt = S_HPLACE2;
      end
      S_HPLACE2: begin
        cmd.op    = ihpt_pkg::OP_HPLACE2;
        state_nxt = S_OUT;
      end
      S_HOLD_RD: begin
        cmd.op    = ihpt_pkg::OP_HOLD_RD;
        state_nxt = S_HOLD_AD;
      end
      S_HOLD_AD: begin
        cmd.op    = ihpt_pkg::OP_HOLD_AD;
        state_nxt = S_OUT;
      end
      S_MISS: begin
        cmd.op    = ihpt_pkg::OP_MISS;
        state_nxt = sts.full ? S_EINFO : S_INS_RD;
      end
      S_EINFO: begin
        cmd.op    = ihpt_pkg::OP_EINFO;
        state_nxt = S_EHEAD;
      end
      S_EHEAD: begin
        cmd.op    = ihpt_pkg::OP_EHEAD;
        state_nxt = sts.head_nil ? S_INS_RD : S_ELINK;
      end
      S_ELINK: begin
        cmd.op = ihpt_pkg::OP_ELINK;
        if (sts.cur_is_frame || sts.link_nil || sts.steps_last) state_nxt = S_INS_RD;
      end
      S_INS_RD: begin
        cmd.op    = ihpt_pkg::OP_INS_RD;
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.op    = ihpt_pkg::OP_INS_WR;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          cmd.op    = ihpt_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // The result word stays valid until the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/ihpt_dp.sv -----
// Datapath: table memories, walk registers, LRU ring pointers and result register.
// Depends on ihpt_pkg and ihpt_ram.
module ihpt_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ihpt_pkg::cmd_t                cmd,
  output ihpt_pkg::sts_t                sts,
  input  logic [ihpt_pkg::PID_W-1:0]    in_pid,
  input  logic [ihpt_pkg::VA_W-1:0]     in_va,
  output logic                          res_hit,
  output logic [ihpt_pkg::FRAME_W-1:0]  res_frame,
  output logic [ihpt_pkg::PA_W-1:0]     res_pa,
  output logic                          res_empty,
  output logic [ihpt_pkg::CNT_W-1:0]    res_cmp,
  output logic                          res_evict
);

  localparam int FW = ihpt_pkg::FRAME_W;
  localparam int PW = ihpt_pkg::PTR_W;
  localparam int IW = ihpt_pkg::INFO_W;
  localparam int CW = ihpt_pkg::CNT_W;

  // Access word and walk registers.
  logic [ihpt_pkg::PID_W-1:0]     pid_r;
  logic [ihpt_pkg::VPN_W-1:0]     vpn_r;
  logic [ihpt_pkg::PAGE_BITS-1:0] off_r;
  logic [FW-1:0] bucket_r, frame_r, cur_r, prev_r, eb_r, oldest_r, clr_r;
  logic          prev_nil_r, empty_r, hit_r, evict_r;
  logic [CW-1:0] cmp_r, steps_r, used_r;

  // Memory ports.
  logic          hd_we, lk_we, inf_we, rp_we, rn_we;
  logic [FW-1:0] hd_wa, lk_wa, inf_wa, rp_wa, rn_wa;
  logic [FW-1:0] hd_ra, lk_ra, inf_ra, rp_ra, rn_ra;
  logic [PW-1:0] hd_wd, lk_wd, hd_q, lk_q;
  logic [IW-1:0] inf_wd, inf_q;
  logic [FW-1:0] rp_wd, rn_wd, rp_q, rn_q;

  logic [ihpt_pkg::VPN_W-1:0] in_vpn;
  logic [FW-1:0]              in_bucket;

  assign in_vpn    = in_va[ihpt_pkg::VA_W-1:ihpt_pkg::PAGE_BITS];
  assign in_bucket = in_vpn[FW-1:0] + FW'(in_pid);

  ihpt_ram #(.W(PW), .D(ihpt_pkg::FRAMES)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_q));
  ihpt_ram #(.W(PW), .D(ihpt_pkg::FRAMES)) u_link (
    .clk, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_q));
  ihpt_ram #(.W(IW), .D(ihpt_pkg::FRAMES)) u_info (
    .clk, .we(inf_we), .waddr(inf_wa), .wdata(inf_wd), .raddr(inf_ra), .rdata(inf_q));
  ihpt_ram #(.W(FW), .D(ihpt_pkg::FRAMES)) u_rprev (
    .clk, .we(rp_we), .waddr(rp_wa), .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_q));
  ihpt_ram #(.W(FW), .D(ihpt_pkg::FRAMES)) u_rnext (
    .clk, .we(rn_we), .waddr(rn_wa), .wdata(rn_wd), .raddr(rn_ra), .rdata(rn_q));

  // Status back to the controller.
  always_comb begin
    sts.head_nil      = hd_q[PW-1];
    sts.link_nil      = lk_q[PW-1];
    sts.match         = (inf_q == {pid_r, vpn_r});
    sts.cur_is_oldest = (cur_r == oldest_r);
    sts.cur_is_frame  = (cur_r == frame_r);
    sts.full          = used_r[CW-1];
    sts.cmp_last      = (cmp_r == CW'(ihpt_pkg::FRAMES - 1));
    sts.steps_last    = (steps_r == CW'(ihpt_pkg::FRAMES - 1));
    sts.clr_last      = (clr_r == FW'(ihpt_pkg::FRAMES - 1));
  end

  // Memory addresses and writes for each step.
  always_comb begin
    hd_we = 1'b0; lk_we = 1'b0; inf_we = 1'b0; rp_we = 1'b0; rn_we = 1'b0;
    hd_wa = '0;   lk_wa = '0;   inf_wa = '0;   rp_wa = '0;   rn_wa = '0;
    hd_wd = ihpt_pkg::NIL; lk_wd = ihpt_pkg::NIL; inf_wd = {pid_r, vpn_r};
    rp_wd = '0;   rn_wd = '0;
    hd_ra = '0;   lk_ra = '0;   inf_ra = '0;   rp_ra = '0;   rn_ra = '0;
    case (cmd.op)
      ihpt_pkg::OP_CLEAR: begin
        hd_we = 1'b1; hd_wa = clr_r;
        lk_we = 1'b1; lk_wa = clr_r;
        rp_we = 1'b1; rp_wa = clr_r; rp_wd = clr_r - FW'(1);
        rn_we = 1'b1; rn_wa = clr_r; rn_wd = clr_r + FW'(1);
      end
      ihpt_pkg::OP_ACCEPT: hd_ra = in_bucket;
      ihpt_pkg::OP_HEAD: begin
        inf_ra = hd_q[FW-1:0];
        lk_ra  = hd_q[FW-1:0];
      end
      ihpt_pkg::OP_CMP: begin
        inf_ra = lk_q[FW-1:0];
        lk_ra  = lk_q[FW-1:0];
      end
      ihpt_pkg::OP_HREAD: begin
        rp_ra = frame_r;
        rn_ra = frame_r;
      end
      ihpt_pkg::OP_HLINK: begin
        // Take the hit frame out of the ring.
        rn_we = 1'b1; rn_wa = rp_q; rn_wd = rn_q;
        rp_we = 1'b1; rp_wa = rn_q; rp_wd = rp_q;
      end
      ihpt_pkg::OP_HBEF: rp_ra = oldest_r;
      ihpt_pkg::OP_HPLACE1: begin
        rn_we = 1'b1; rn_wa = rp_q;    rn_wd = frame_r;
        rp_we = 1'b1; rp_wa = frame_r; rp_wd = rp_q;
      end
      ihpt_pkg::OP_HPLACE2: begin
        rn_we = 1'b1; rn_wa = frame_r;  rn_wd = oldest_r;
        rp_we = 1'b1; rp_wa = oldest_r; rp_wd = frame_r;
      end
      ihpt_pkg::OP_HOLD_RD: rn_ra = oldest_r;
      ihpt_pkg::OP_MISS: inf_ra = oldest_r;
      ihpt_pkg::OP_EINFO: hd_ra = inf_q[FW-1:0] + FW'(inf_q[IW-1:ihpt_pkg::VPN_W]);
      ihpt_pkg::OP_EHEAD: lk_ra = hd_q[FW-1:0];
      ihpt_pkg::OP_ELINK: begin
        if (cur_r == frame_r) begin
          // Unlink the victim from its old chain.
          if (prev_nil_r) begin
            hd_we = 1'b1; hd_wa = eb_r; hd_wd = lk_q;
          end else begin
            lk_we = 1'b1; lk_wa = prev_r; lk_wd = lk_q;
          end
        end else begin
          lk_ra = lk_q[FW-1:0];
        end
      end
      ihpt_pkg::OP_INS_RD: begin
        hd_ra = bucket_r;
        rn_ra = oldest_r;
      end
      ihpt_pkg::OP_INS_WR: begin
        lk_we  = 1'b1; lk_wa  = frame_r;  lk_wd = hd_q;
        hd_we  = 1'b1; hd_wa  = bucket_r; hd_wd = {1'b0, frame_r};
        inf_we = 1'b1; inf_wa = frame_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers: clearing sweep, oldest frame and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      oldest_r <= '0;
      used_r   <= '0;
    end else begin
      case (cmd.op) inside
        ihpt_pkg::OP_CLEAR:  clr_r <= clr_r + FW'(1);
        ihpt_pkg::OP_HOLD_AD,
        ihpt_pkg::OP_INS_WR: oldest_r <= rn_q;
        ihpt_pkg::OP_MISS:   if (!used_r[CW-1]) used_r <= used_r + CW'(1);
        default: begin
        end
      endcase
    end
  end

  // Walk and payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ihpt_pkg::OP_ACCEPT: begin
        pid_r    <= in_pid;
        vpn_r    <= in_vpn;
        off_r    <= in_va[ihpt_pkg::PAGE_BITS-1:0];
        bucket_r <= in_bucket;
        cmp_r    <= '0;
        hit_r    <= 1'b0;
        evict_r  <= 1'b0;
      end
      ihpt_pkg::OP_HEAD: begin
        empty_r <= hd_q[PW-1];
        cur_r   <= hd_q[FW-1:0];
      end
      ihpt_pkg::OP_CMP: begin
        cmp_r <= cmp_r + CW'(1);
        if (sts.match) begin
          hit_r   <= 1'b1;
          frame_r <= cur_r;
        end else begin
          cur_r <= lk_q[FW-1:0];
        end
      end
      ihpt_pkg::OP_MISS: begin
        frame_r <= oldest_r;
        evict_r <= used_r[CW-1];
      end
      ihpt_pkg::OP_EINFO: begin
        eb_r       <= inf_q[FW-1:0] + FW'(inf_q[IW-1:ihpt_pkg::VPN_W]);
        prev_nil_r <= 1'b1;
        steps_r    <= '0;
      end
      ihpt_pkg::OP_EHEAD: cur_r <= hd_q[FW-1:0];
      ihpt_pkg::OP_ELINK: begin
        if (cur_r != frame_r) begin
          prev_r     <= cur_r;
          prev_nil_r <= 1'b0;
          cur_r      <= lk_q[FW-1:0];
          steps_r    <= steps_r + CW'(1);
        end
      end
      ihpt_pkg::OP_OUT: begin
        res_hit   <= hit_r;
        res_frame <= frame_r;
        res_pa    <= {frame_r, off_r};
        res_empty <= empty_r;
        res_cmp   <= cmp_r;
        res_evict <= evict_r;
      end
      default: begin
      end
    endcase
  end

endmodule
